[rtl/core/ssd_pkg.sv]
// shared types and constants of the spi sample stream decoder
package ssd_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDataW = 8;
  localparam logic [CfgIdxW-1:0] REG_CLOCK_IDLE_HIGH      = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_SAMPLE_TRAILING_EDGE = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_LSB_FIRST_ORDER      = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_WORD_BITS            = 8'd3;
  localparam logic [CfgIdxW-1:0] REG_USE_CHIP_SELECT      = 8'd4;
  localparam logic [CfgIdxW-1:0] REG_MOSI_PRESENT         = 8'd5;
  localparam logic [CfgIdxW-1:0] REG_MISO_PRESENT         = 8'd6;

  localparam int unsigned WordBitsW = 7;
  localparam logic [WordBitsW-1:0] WORD_BITS_RESET = 7'd8;

  // output and input field widths
  localparam int unsigned OutTimeW = 32;
  localparam int unsigned OutWordW = 64;
  localparam int unsigned InTimeW = 32;

  typedef struct packed {
    logic                 clock_idle_high;
    logic                 sample_trailing_edge;
    logic                 lsb_first_order;
    logic [WordBitsW-1:0] word_bits;
    logic                 use_chip_select;
    logic                 mosi_present;
    logic                 miso_present;
  } cfg_t;

  // operation handed from the front end to the back end
  typedef enum logic {
    OP_TAKE  = 1'b0,
    OP_FLUSH = 1'b1
  } op_kind_e;

  typedef struct packed {
    op_kind_e kind;
    logic     mosi_val;
    logic     miso_val;
  } op_t;

endpackage

[rtl/core/ssd_front.sv]
// front end: clock edge detection and sample classification
module ssd_front #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ssd_pkg::cfg_t                  cfg_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           select_level_i,
  input  logic                           clk_level_i,
  input  logic                           mosi_level_i,
  input  logic                           miso_level_i,
  input  logic [ssd_pkg::InTimeW-1:0]    sample_time_i,
  input  logic                           queue_full_i,
  output logic                           push_o,
  output ssd_pkg::op_t                   push_op_o,
  output logic [TIME_WIDTH-1:0]          push_time_o
);

  logic last_clock_q, last_clock_d;
  logic accept;
  logic deselect;
  logic rose, fell, leading, trailing, take;

  assign in_ready_o = !queue_full_i;
  assign accept = in_valid_i && in_ready_o;
  assign deselect = cfg_i.use_chip_select && select_level_i;

  assign rose = !last_clock_q && clk_level_i;
  assign fell = last_clock_q && !clk_level_i;
  assign leading = cfg_i.clock_idle_high ? fell : rose;
  assign trailing = cfg_i.clock_idle_high ? rose : fell;
  assign take = cfg_i.sample_trailing_edge ? trailing : leading;

  always_comb begin
    last_clock_d = last_clock_q;
    push_o = 1'b0;
    push_op_o.kind = ssd_pkg::OP_TAKE;
    // absent lines read as zero
    push_op_o.mosi_val = cfg_i.mosi_present && mosi_level_i;
    push_op_o.miso_val = cfg_i.miso_present && miso_level_i;
    if (accept) begin
      if (deselect) begin
        last_clock_d = cfg_i.clock_idle_high;
        push_o = 1'b1;
        push_op_o.kind = ssd_pkg::OP_FLUSH;
      end else begin
        last_clock_d = clk_level_i;
        push_o = take;
      end
    end
  end

  assign push_time_o = TIME_WIDTH'(sample_time_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_clock_q <= 1'b0;
    end else begin
      last_clock_q <= last_clock_d;
    end
  end

endmodule

[rtl/core/ssd_queue.sv]
// short operation queue between front end and back end
module ssd_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o = (count_q == CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= wdata_i;
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");
`endif

endmodule

[rtl/core/ssd_back.sv]
// back end: word assembly and output register
module ssd_back #(
  parameter int unsigned WORD_MAX   = 64,
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ssd_pkg::cfg_t                  cfg_i,
  input  logic                           op_valid_i,
  input  ssd_pkg::op_t                   op_i,
  input  logic [TIME_WIDTH-1:0]          op_time_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ssd_pkg::OutTimeW-1:0]   word_start_time_o,
  output logic [ssd_pkg::OutTimeW-1:0]   word_end_time_o,
  output logic [ssd_pkg::OutWordW-1:0]   mosi_word_o,
  output logic [ssd_pkg::OutWordW-1:0]   miso_word_o,
  output logic                           short_word_o
);

  localparam int unsigned CntW = $clog2(WORD_MAX + 1);
  localparam int unsigned PosW = $clog2(WORD_MAX);

  logic                  active_q, active_d;
  logic [WORD_MAX-1:0]   mosi_q, mosi_d, miso_q, miso_d;
  logic [CntW-1:0]       bits_q, bits_d;
  logic [TIME_WIDTH-1:0] begin_q, begin_d;

  logic [CntW-1:0]       len;
  logic [WORD_MAX-1:0]   mosi_base, miso_base, mosi_next, miso_next;
  logic [CntW-1:0]       bits_base, bits_next;
  logic [TIME_WIDTH-1:0] begin_base;
  logic [PosW-1:0]       pos;

  logic                  emit;
  logic                  emit_short;
  logic [TIME_WIDTH-1:0] emit_start;
  logic [WORD_MAX-1:0]   emit_mosi, emit_miso;

  logic                           out_valid_q, out_valid_d;
  logic [ssd_pkg::OutTimeW-1:0]   start_q, end_q;
  logic [ssd_pkg::OutWordW-1:0]   out_mosi_q, out_miso_q;
  logic                           short_q;

  // word length clamped into 1..WORD_MAX
  always_comb begin
    if (cfg_i.word_bits == '0) begin
      len = CntW'(1);
    end else if (cfg_i.word_bits > WORD_MAX) begin
      len = CntW'(WORD_MAX);
    end else begin
      len = CntW'(cfg_i.word_bits);
    end
  end

  // one operation per cycle unless a result waits at the output and is not taken
  assign pop_o = op_valid_i && (!out_valid_q || out_ready_i);

  // a sampling edge with no word open starts a fresh one at this time
  assign mosi_base = active_q ? mosi_q : '0;
  assign miso_base = active_q ? miso_q : '0;
  assign bits_base = active_q ? bits_q : '0;
  assign begin_base = active_q ? begin_q : op_time_i;
  assign pos = PosW'(bits_base);
  assign bits_next = bits_base + 1'b1;

  always_comb begin
    if (cfg_i.lsb_first_order) begin
      mosi_next = mosi_base | (WORD_MAX'(op_i.mosi_val) << pos);
      miso_next = miso_base | (WORD_MAX'(op_i.miso_val) << pos);
    end else begin
      mosi_next = {mosi_base[WORD_MAX-2:0], op_i.mosi_val};
      miso_next = {miso_base[WORD_MAX-2:0], op_i.miso_val};
    end
  end

  always_comb begin
    active_d = active_q;
    mosi_d = mosi_q;
    miso_d = miso_q;
    bits_d = bits_q;
    begin_d = begin_q;
    emit = 1'b0;
    emit_short = 1'b0;
    emit_start = begin_q;
    emit_mosi = mosi_q;
    emit_miso = miso_q;
    if (pop_o) begin
      case (op_i.kind)
        ssd_pkg::OP_FLUSH: begin
          emit = active_q && (bits_q != '0);
          emit_short = (bits_q != len);
          active_d = 1'b0;
          bits_d = '0;
          mosi_d = '0;
          miso_d = '0;
        end
        ssd_pkg::OP_TAKE: begin
          active_d = 1'b1;
          emit_start = begin_base;
          emit_mosi = mosi_next;
          emit_miso = miso_next;
          if (bits_next >= len) begin
            // full word: the next one starts at this edge
            emit = 1'b1;
            mosi_d = '0;
            miso_d = '0;
            bits_d = '0;
            begin_d = op_time_i;
          end else begin
            mosi_d = mosi_next;
            miso_d = miso_next;
            bits_d = bits_next;
            begin_d = begin_base;
          end
        end
        default: begin
          active_d = active_q;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      bits_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q <= active_d;
      bits_q <= bits_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mosi_q <= mosi_d;
    miso_q <= miso_d;
    begin_q <= begin_d;
    if (emit) begin
      start_q <= ssd_pkg::OutTimeW'(emit_start);
      end_q <= ssd_pkg::OutTimeW'(op_time_i);
      out_mosi_q <= ssd_pkg::OutWordW'(emit_mosi);
      out_miso_q <= ssd_pkg::OutWordW'(emit_miso);
      short_q <= emit_short;
    end
  end

  assign out_valid_o = out_valid_q;
  assign word_start_time_o = start_q;
  assign word_end_time_o = end_q;
  assign mosi_word_o = out_mosi_q;
  assign miso_word_o = out_miso_q;
  assign short_word_o = short_q;

`ifndef ASSERT_OFF
  a_bits_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_q < CntW'(WORD_MAX))
    else $error("bit count reached word limit without emitting");

  a_idle_no_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (bits_q == '0))
    else $error("bits held while no word is open");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_o)
    else $error("emitted word not presented");

  a_full_word_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !emit_short) |=> (bits_q == '0))
    else $error("bit count not cleared after word");
`endif

endmodule

[rtl/core/spi_sample_stream_decoder.sv]
// top level of the spi sample stream decoder
//
// Decodes a stream of logic-analyser samples (chip select, clock, mosi, miso,
// timestamp) into spi words using the configured polarity, phase, bit order
// and word length. One sample is accepted per clock cycle. Samples with no
// sampling edge and no deselect are consumed by the front end alone; the
// others become operations in a four-entry queue that the back end retires
// one per cycle, so the sustained rate is one sample per cycle as long as the
// output transfers are taken. A result reaches the output by way of the queue
// and the output register. When the output is stalled the queue fills and
// in_ready_o drops. Configuration writes are always accepted and must only
// be issued while the decoder is idle.
module spi_sample_stream_decoder #(
  parameter int unsigned WORD_MAX   = 64,
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ssd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ssd_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          select_level_i,
  input  logic                          clk_level_i,
  input  logic                          mosi_level_i,
  input  logic                          miso_level_i,
  input  logic [ssd_pkg::InTimeW-1:0]   sample_time_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ssd_pkg::OutTimeW-1:0]  word_start_time_o,
  output logic [ssd_pkg::OutTimeW-1:0]  word_end_time_o,
  output logic [ssd_pkg::OutWordW-1:0]  mosi_word_o,
  output logic [ssd_pkg::OutWordW-1:0]  miso_word_o,
  output logic                          short_word_o
);

  localparam int unsigned OpW = $bits(ssd_pkg::op_t);
  localparam int unsigned QueueW = TIME_WIDTH + OpW;
  localparam int unsigned QueueDepth = 4;

  ssd_pkg::cfg_t cfg_q;

  logic                  push;
  ssd_pkg::op_t          push_op;
  logic [TIME_WIDTH-1:0] push_time;
  logic                  queue_full;
  logic                  pop;
  logic                  queue_valid;
  logic [QueueW-1:0]     queue_rdata;
  ssd_pkg::op_t          pop_op;
  logic [TIME_WIDTH-1:0] pop_time;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clock_idle_high <= 1'b0;
      cfg_q.sample_trailing_edge <= 1'b0;
      cfg_q.lsb_first_order <= 1'b0;
      cfg_q.word_bits <= ssd_pkg::WORD_BITS_RESET;
      cfg_q.use_chip_select <= 1'b1;
      cfg_q.mosi_present <= 1'b1;
      cfg_q.miso_present <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        ssd_pkg::REG_CLOCK_IDLE_HIGH: begin
          cfg_q.clock_idle_high <= cfg_data_i[0];
        end
        ssd_pkg::REG_SAMPLE_TRAILING_EDGE: begin
          cfg_q.sample_trailing_edge <= cfg_data_i[0];
        end
        ssd_pkg::REG_LSB_FIRST_ORDER: begin
          cfg_q.lsb_first_order <= cfg_data_i[0];
        end
        ssd_pkg::REG_WORD_BITS: begin
          cfg_q.word_bits <= cfg_data_i[ssd_pkg::WordBitsW-1:0];
        end
        ssd_pkg::REG_USE_CHIP_SELECT: begin
          cfg_q.use_chip_select <= cfg_data_i[0];
        end
        ssd_pkg::REG_MOSI_PRESENT: begin
          cfg_q.mosi_present <= cfg_data_i[0];
        end
        ssd_pkg::REG_MISO_PRESENT: begin
          cfg_q.miso_present <= cfg_data_i[0];
        end
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  ssd_front #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .select_level_i (select_level_i),
    .clk_level_i    (clk_level_i),
    .mosi_level_i   (mosi_level_i),
    .miso_level_i   (miso_level_i),
    .sample_time_i  (sample_time_i),
    .queue_full_i   (queue_full),
    .push_o         (push),
    .push_op_o      (push_op),
    .push_time_o    (push_time)
  );

  ssd_queue #(
    .WIDTH (QueueW),
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({push_time, push_op}),
    .full_o  (queue_full),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .rdata_o (queue_rdata)
  );

  assign pop_op = ssd_pkg::op_t'(queue_rdata[OpW-1:0]);
  assign pop_time = queue_rdata[QueueW-1:OpW];

  ssd_back #(
    .WORD_MAX   (WORD_MAX),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .op_valid_i        (queue_valid),
    .op_i              (pop_op),
    .op_time_i         (pop_time),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .word_start_time_o (word_start_time_o),
    .word_end_time_o   (word_end_time_o),
    .mosi_word_o       (mosi_word_o),
    .miso_word_o       (miso_word_o),
    .short_word_o      (short_word_o)
  );

endmodule

[tb/tb_top.sv]
// self-checking testbench for the spi sample stream decoder
module tb_top;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_SAMPLES = 40;
  localparam int unsigned NUM_PHASES = 9;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned CfgBits = $bits(ssd_pkg::cfg_t);
  localparam logic [ssd_pkg::CfgIdxW-1:0] REG_PAST_END = 8'd7;
  localparam logic [ssd_pkg::CfgIdxW-1:0] REG_INDEX_TOP = 8'hFF;

  typedef struct packed {
    logic                        sel;
    logic                        clk;
    logic                        mosi;
    logic                        miso;
    logic [ssd_pkg::InTimeW-1:0] stamp;
  } sample_t;

  typedef struct packed {
    logic [ssd_pkg::OutTimeW-1:0] t_begin;
    logic [ssd_pkg::OutTimeW-1:0] t_end;
    logic [ssd_pkg::OutWordW-1:0] mosi;
    logic [ssd_pkg::OutWordW-1:0] miso;
    logic                         cut;
  } word_rec_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [ssd_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [ssd_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  sample_t                      drv_sample = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [ssd_pkg::OutTimeW-1:0] word_start_time_o;
  logic [ssd_pkg::OutTimeW-1:0] word_end_time_o;
  logic [ssd_pkg::OutWordW-1:0] mosi_word_o;
  logic [ssd_pkg::OutWordW-1:0] miso_word_o;
  logic                         short_word_o;

  // decoder state as the testbench expects it
  ssd_pkg::cfg_t dec_cfg = '{clock_idle_high: 1'b0, sample_trailing_edge: 1'b0,
                             lsb_first_order: 1'b0,
                             word_bits: ssd_pkg::WORD_BITS_RESET,
                             use_chip_select: 1'b1, mosi_present: 1'b1,
                             miso_present: 1'b1};
  logic                         frame_open = 1'b0;
  logic [ssd_pkg::OutWordW-1:0] mosi_acc = '0;
  logic [ssd_pkg::OutWordW-1:0] miso_acc = '0;
  logic [6:0]                   acc_bits = '0;
  logic [ssd_pkg::OutTimeW-1:0] frame_t0 = '0;
  logic                         last_clk_lvl = 1'b0;

  word_rec_t   words_due[$];
  sample_t     samples_pending[$];
  int unsigned samples_queued = 0;
  int unsigned samples_taken = 0;
  int unsigned words_checked = 0;
  int unsigned short_words = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        sample_fire = 1'b0;
  logic [ssd_pkg::InTimeW-1:0] stamp_now = '0;

  spi_sample_stream_decoder u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .select_level_i    (drv_sample.sel),
    .clk_level_i       (drv_sample.clk),
    .mosi_level_i      (drv_sample.mosi),
    .miso_level_i      (drv_sample.miso),
    .sample_time_i     (drv_sample.stamp),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .word_start_time_o (word_start_time_o),
    .word_end_time_o   (word_end_time_o),
    .mosi_word_o       (mosi_word_o),
    .miso_word_o       (miso_word_o),
    .short_word_o      (short_word_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic int unsigned word_len(input logic [ssd_pkg::WordBitsW-1:0] wb);
    if (wb == 0) return 1;
    if (wb > ssd_pkg::OutWordW) return ssd_pkg::OutWordW;
    return wb;
  endfunction

  function automatic void apply_cfg(input logic [ssd_pkg::CfgIdxW-1:0] idx,
                                    input logic [ssd_pkg::CfgDataW-1:0] data);
    case (idx)
      ssd_pkg::REG_CLOCK_IDLE_HIGH:      dec_cfg.clock_idle_high = data[0];
      ssd_pkg::REG_SAMPLE_TRAILING_EDGE: dec_cfg.sample_trailing_edge = data[0];
      ssd_pkg::REG_LSB_FIRST_ORDER:      dec_cfg.lsb_first_order = data[0];
      ssd_pkg::REG_WORD_BITS:            dec_cfg.word_bits = data[ssd_pkg::WordBitsW-1:0];
      ssd_pkg::REG_USE_CHIP_SELECT:      dec_cfg.use_chip_select = data[0];
      ssd_pkg::REG_MOSI_PRESENT:         dec_cfg.mosi_present = data[0];
      ssd_pkg::REG_MISO_PRESENT:         dec_cfg.miso_present = data[0];
      default: ;
    endcase
  endfunction

  task automatic decode_sample(input sample_t s);
    logic        idle;
    logic        mbit;
    logic        sbit;
    logic        rose;
    logic        fell;
    logic        take;
    int unsigned len;
    word_rec_t   w;
    idle = dec_cfg.clock_idle_high;
    len = word_len(dec_cfg.word_bits);
    mbit = dec_cfg.mosi_present & s.mosi;
    sbit = dec_cfg.miso_present & s.miso;
    if (dec_cfg.use_chip_select && s.sel) begin
      // deselect flushes a partial word and parks the clock at idle
      if (frame_open && acc_bits != 0) begin
        w = '{frame_t0, s.stamp, mosi_acc, miso_acc, (acc_bits != len)};
        words_due.insert(words_due.size(), w);
      end
      frame_open = 1'b0;
      acc_bits = '0;
      mosi_acc = '0;
      miso_acc = '0;
      last_clk_lvl = idle;
      return;
    end
    rose = !last_clk_lvl && s.clk;
    fell = last_clk_lvl && !s.clk;
    last_clk_lvl = s.clk;
    if (dec_cfg.sample_trailing_edge) take = idle ? rose : fell;
    else take = idle ? fell : rose;
    if (!take) return;
    if (!frame_open) begin
      frame_open = 1'b1;
      frame_t0 = s.stamp;
      mosi_acc = '0;
      miso_acc = '0;
      acc_bits = '0;
    end
    if (dec_cfg.lsb_first_order) begin
      mosi_acc = mosi_acc | (ssd_pkg::OutWordW'(mbit) << acc_bits[5:0]);
      miso_acc = miso_acc | (ssd_pkg::OutWordW'(sbit) << acc_bits[5:0]);
    end else begin
      mosi_acc = {mosi_acc[ssd_pkg::OutWordW-2:0], mbit};
      miso_acc = {miso_acc[ssd_pkg::OutWordW-2:0], sbit};
    end
    acc_bits = acc_bits + 7'd1;
    if (acc_bits >= len) begin
      w = '{frame_t0, s.stamp, mosi_acc, miso_acc, 1'b0};
      words_due.insert(words_due.size(), w);
      mosi_acc = '0;
      miso_acc = '0;
      acc_bits = '0;
      // next word starts where this one ended
      frame_t0 = s.stamp;
    end
  endtask

  task automatic check_word();
    word_rec_t got;
    word_rec_t want;
    got = '{word_start_time_o, word_end_time_o, mosi_word_o, miso_word_o, short_word_o};
    words_checked++;
    if (got.cut) short_words++;
    if (words_due.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("unexpected word at cycle %0d: start %h end %h mosi %h miso %h short %b",
                 cycle_count, got.t_begin, got.t_end, got.mosi, got.miso, got.cut);
    end else begin
      want = words_due.pop_front();
      if (got !== want) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("word %0d mismatch at cycle %0d", words_checked, cycle_count);
          $display("  expected start %h end %h mosi %h miso %h short %b",
                   want.t_begin, want.t_end, want.mosi, want.miso, want.cut);
          $display("  actual   start %h end %h mosi %h miso %h short %b",
                   got.t_begin, got.t_end, got.mosi, got.miso, got.cut);
        end
      end
    end
  endtask

  // monitor: config, sample and word transfers at the rising edge
  always @(posedge clk_i) begin
    sample_fire = 1'b0;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) apply_cfg(cfg_index_i, cfg_data_i);
      sample_fire = in_valid_i && in_ready_o;
      if (sample_fire) begin
        decode_sample(drv_sample);
        samples_taken++;
      end
      if (out_valid_o && out_ready_i) check_word();
    end
  end

  // driver: next sample and output stall at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || sample_fire) begin
        if (samples_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          drv_sample <= samples_pending.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still due", cycle_count, words_due.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_sample(input logic sel, input logic clk, input logic mosi,
                             input logic miso, input logic [ssd_pkg::InTimeW-1:0] stamp);
    sample_t s;
    s = '{sel, clk, mosi, miso, stamp};
    samples_pending.insert(samples_pending.size(), s);
    samples_queued++;
  endtask

  task automatic push_line(input logic sel, input logic clk);
    if ($urandom_range(0, 49) == 0) stamp_now = $urandom;
    else stamp_now = stamp_now + $urandom_range(1, 40);
    push_sample(sel, clk, 1'($urandom), 1'($urandom), stamp_now);
  endtask

  // one select window of clock pulses with random data, or a burst of noise
  task automatic add_frame(input ssd_pkg::cfg_t c);
    int unsigned len;
    int unsigned nbits;
    len = word_len(c.word_bits);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) push_line(1'($urandom), 1'($urandom));
      return;
    end
    if ($urandom_range(0, 3) != 0) push_line(1'b1, 1'($urandom));
    push_line(1'b0, c.clock_idle_high);
    if ($urandom_range(0, 3) == 0) nbits = $urandom_range(1, len);
    else if (len <= 8) nbits = len * $urandom_range(1, 3);
    else nbits = len;
    repeat (nbits) begin
      push_line(1'b0, !c.clock_idle_high);
      if ($urandom_range(0, 7) == 0) push_line(1'b0, !c.clock_idle_high);
      push_line(1'b0, c.clock_idle_high);
    end
    if ($urandom_range(0, 3) != 0) push_line(1'b1, 1'($urandom));
  endtask

  task automatic write_reg(input logic [ssd_pkg::CfgIdxW-1:0] idx,
                           input logic [ssd_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic wait_quiet();
    while (samples_taken != samples_queued || words_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    ssd_pkg::cfg_t pc;
    int unsigned   phase_base;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    send_idle_pct = 30;
    recv_stall_pct = 85;

    // two-bit words; bit 7 of the data lies above the field
    write_reg(ssd_pkg::REG_WORD_BITS, 8'h82);
    push_sample(1'b1, 1'b0, 1'b0, 1'b0, 32'h0000_0000);
    push_sample(1'b0, 1'b0, 1'b0, 1'b0, 32'h0000_0001);
    push_sample(1'b0, 1'b1, 1'b1, 1'b0, 32'h0000_0002);
    push_sample(1'b0, 1'b0, 1'b0, 1'b0, 32'h0000_0003);
    push_sample(1'b0, 1'b1, 1'b0, 1'b1, 32'h0000_0004);
    push_sample(1'b0, 1'b0, 1'b0, 1'b0, 32'h0000_0005);
    push_sample(1'b0, 1'b1, 1'b1, 1'b1, 32'h0000_0006);
    push_sample(1'b1, 1'b0, 1'b0, 1'b0, 32'h0000_0007);
    push_sample(1'b1, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
    push_sample(1'b0, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFE);
    push_sample(1'b0, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
    push_sample(1'b0, 1'b0, 1'b0, 1'b0, 32'h0000_0000);
    push_sample(1'b0, 1'b1, 1'b1, 1'b1, 32'h0000_0001);
    wait_quiet();
    // polarity flips while the clock is high and the word stream is still open
    write_reg(ssd_pkg::REG_CLOCK_IDLE_HIGH, 8'h01);
    push_sample(1'b0, 1'b0, 1'b1, 1'b0, 32'h0000_0002);
    push_sample(1'b0, 1'b1, 1'b0, 1'b0, 32'h0000_0003);
    push_sample(1'b0, 1'b0, 1'b0, 1'b1, 32'h0000_0004);
    push_sample(1'b1, 1'b1, 1'b0, 1'b0, 32'h0000_0005);
    wait_quiet();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 3) begin
        send_idle_pct = 85;
        recv_stall_pct = 30;
      end else if (ph == 6) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      pc = CfgBits'($urandom);
      case (ph)
        0: pc = '{1'b0, 1'b0, 1'b0, 7'd8, 1'b1, 1'b1, 1'b1};
        1: pc = '{1'b1, 1'b1, 1'b1, 7'd64, 1'b1, 1'b1, 1'b1};
        2: pc = '{1'b0, 1'b1, 1'b0, 7'd1, 1'b1, 1'b1, 1'b0};
        3: pc = '{1'b1, 1'b0, 1'b1, 7'd0, 1'b1, 1'b0, 1'b1};
        4: pc = '{1'b0, 1'b0, 1'b1, 7'd127, 1'b1, 1'b1, 1'b1};
        5: pc = '{1'b1, 1'b1, 1'b0, 7'($urandom_range(2, 63)), 1'b0, 1'b1, 1'b1};
        6: pc.word_bits = 7'($urandom_range(0, 20));
        8: pc = '{1'b0, 1'b1, 1'b1, 7'd16, 1'b1, 1'b1, 1'b1};
        default: ;
      endcase
      // upper data bits are noise the decoder must drop
      write_reg(REG_PAST_END, 8'($urandom));
      write_reg(ssd_pkg::REG_CLOCK_IDLE_HIGH, {7'($urandom), pc.clock_idle_high});
      write_reg(ssd_pkg::REG_SAMPLE_TRAILING_EDGE, {7'($urandom), pc.sample_trailing_edge});
      write_reg(ssd_pkg::REG_LSB_FIRST_ORDER, {7'($urandom), pc.lsb_first_order});
      write_reg(ssd_pkg::REG_WORD_BITS, {1'($urandom), pc.word_bits});
      write_reg(ssd_pkg::REG_USE_CHIP_SELECT, {7'($urandom), pc.use_chip_select});
      write_reg(ssd_pkg::REG_MOSI_PRESENT, {7'($urandom), pc.mosi_present});
      write_reg(ssd_pkg::REG_MISO_PRESENT, {7'($urandom), pc.miso_present});
      write_reg(REG_INDEX_TOP, 8'($urandom));
      phase_base = samples_queued;
      while (samples_queued - phase_base < PHASE_SAMPLES) add_frame(pc);
      wait_quiet();
    end

    $display("%0d samples decoded under %0d register settings and three idle patterns",
             samples_taken, NUM_PHASES + 2);
    $display("%0d words checked, %0d cut short by deselect, %0d failures",
             words_checked, short_words, fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
